[src/joystick_axis_response_curve_core_assert.svh]
// Assertion macros for the joystick axis response curve core.
// JARC_ASSERT checks a property on every clock edge outside reset.
// JARC_ASSERT_ALWAYS checks a property on every clock edge, reset included.
`ifndef JOYSTICK_AXIS_RESPONSE_CURVE_CORE_ASSERT_SVH
`define JOYSTICK_AXIS_RESPONSE_CURVE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define JARC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define JARC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define JARC_ASSERT(lbl, prop, msg)
`define JARC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[src/jarc_pkg.sv]
package jarc_pkg;

  localparam int CURVE_TABLE_DEPTH = 256;
  localparam int MAX_CURVE_POWER   = 4;

  localparam int TAB_IDX_W = $clog2(CURVE_TABLE_DEPTH);
  localparam int TAB_W     = 18;
  localparam int EXP_W     = $clog2(MAX_CURVE_POWER * 65536 + 1);
  localparam int RECIP_W   = 17;

  localparam logic [16:0] Q15_ONE    = 17'd32768;
  localparam logic [16:0] SAT_MARGIN = 17'd328;

  localparam int DIV_STAGES = 8;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_X_NEG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_X_POS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_Y_NEG = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_Y_POS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CURVATURE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd7;

  // Per-sample classification that travels beside the arithmetic.
  typedef struct packed {
    logic dz;
    logic sat;
    logic neg;
  } side_t;

  // Partial state of the restoring divider.
  typedef struct packed {
    logic [15:0] rem;
    logic [15:0] den;
    logic [15:0] quo;
  } div_t;

  typedef logic [TAB_W-1:0] tab_t [0:CURVE_TABLE_DEPTH];

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bv;
    n   = n_in;
    res = 64'd0;
    bv  = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bv > n) bv = bv >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bv != 64'd0) begin
        if (n >= res + bv) begin
          n   = n - (res + bv);
          res = (res >> 1) + bv;
        end else begin
          res = res >> 1;
        end
        bv = bv >> 2;
      end
    end
    return res;
  endfunction

  // log2(1 + i/depth) in Q16.
  function automatic tab_t build_log_tab();
    tab_t        t;
    logic [63:0] x;
    logic [31:0] y;
    logic [31:0] bv;
    for (int i = 0; i < CURVE_TABLE_DEPTH; i++) begin
      x  = (64'd1 << 30) + ((64'(i) << 30) / CURVE_TABLE_DEPTH);
      y  = 32'd0;
      bv = 32'd1 << 17;
      for (int k = 0; k < 18; k++) begin
        x = (x * x) >> 30;
        if (x >= (64'd1 << 31)) begin
          x = x >> 1;
          y = y | bv;
        end
        bv = bv >> 1;
      end
      t[i] = TAB_W'((y + 32'd2) >> 2);
    end
    t[CURVE_TABLE_DEPTH] = TAB_W'(65536);
    return t;
  endfunction

  // 2^(i/depth) in Q16.
  function automatic tab_t build_exp_tab();
    tab_t        t;
    logic [63:0] roots [20];
    logic [63:0] acc;
    logic [63:0] f;
    roots[0] = isqrt64(64'd1 << 61);
    for (int k = 1; k < 20; k++) roots[k] = isqrt64(roots[k-1] << 30);
    for (int i = 0; i < CURVE_TABLE_DEPTH; i++) begin
      f   = (64'(i) << 20) / CURVE_TABLE_DEPTH;
      acc = 64'd1 << 30;
      for (int k = 0; k < 20; k++) begin
        if (f[19-k]) acc = (acc * roots[k] + (64'd1 << 29)) >> 30;
      end
      t[i] = TAB_W'((acc + (64'd1 << 13)) >> 14);
    end
    t[CURVE_TABLE_DEPTH] = TAB_W'(131072);
    return t;
  endfunction

  localparam tab_t LOG_TAB = build_log_tab();
  localparam tab_t EXP_TAB = build_exp_tab();

endpackage

[src/joystick_axis_response_curve_core.sv]
// Joystick axis response curve core.
// The input channel (in_valid_i / in_ready_o) carries one signed 16-bit axis
// sample per transfer; the output channel (out_valid_o / out_ready_i) carries
// the shaped command with its deadzone and saturation flags. Each sample gives
// exactly one result, in order.
// The datapath is an 18-stage pipeline: classification, eight divider stages
// of two quotient bits each, seven stages of log/exp power evaluation, the
// Y-limit multiply and the gain multiply. One sample is taken every cycle
// while the output side does not stall the pipeline and no curvature
// write or reciprocal is in progress.
// When the receiver stalls, valid stages hold and empty stages keep filling,
// so the input side stops only once every stage is occupied.
// Registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i, by the
// user only while the pipeline is empty; the block does not enforce this.
// In_ready_o is low in the cycle of any curvature write; a negative curvature
// then starts a serial reciprocal of the exponent, keeping in_ready_o low.
// Reset restores the register defaults (unity curve, full range, gain one).
`include "joystick_axis_response_curve_core_assert.svh"
module joystick_axis_response_curve_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [15:0]                 raw_axis_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [19:0]                 command_value_o,
  output logic                               in_deadzone_o,
  output logic                               saturated_o,
  input  logic                               cfg_we_i,
  input  logic [jarc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [15:0]                        cfg_wdata_i
);

  localparam int NDS = jarc_pkg::DIV_STAGES;

  // Configuration registers.
  logic [15:0] deadzone_q, sxn_q, sxp_q, syn_q, syp_q, curv_q, gain_q;
  logic        invert_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q <= 16'd0;
      sxn_q      <= 16'd32768;
      sxp_q      <= 16'd32768;
      syn_q      <= 16'd32768;
      syp_q      <= 16'd32768;
      curv_q     <= 16'd0;
      invert_q   <= 1'b0;
      gain_q     <= 16'd4096;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        jarc_pkg::REG_DEADZONE:  deadzone_q <= cfg_wdata_i;
        jarc_pkg::REG_SAT_X_NEG: sxn_q      <= cfg_wdata_i;
        jarc_pkg::REG_SAT_X_POS: sxp_q      <= cfg_wdata_i;
        jarc_pkg::REG_SAT_Y_NEG: syn_q      <= cfg_wdata_i;
        jarc_pkg::REG_SAT_Y_POS: syp_q      <= cfg_wdata_i;
        jarc_pkg::REG_CURVATURE: curv_q     <= cfg_wdata_i;
        jarc_pkg::REG_INVERT:    invert_q   <= cfg_wdata_i[0];
        jarc_pkg::REG_GAIN:      gain_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The exponent only changes on a curvature write, so it is kept ready
  // in a register rather than recomputed per sample.
  logic                       curv_wr;
  logic [jarc_pkg::EXP_W-1:0] expo;
  logic                       recip_busy;

  assign curv_wr = cfg_we_i && (cfg_idx_i == jarc_pkg::REG_CURVATURE);

  jarc_recip u_recip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (curv_wr),
    .curv_i  (cfg_wdata_i),
    .expo_o  (expo),
    .busy_o  (recip_busy)
  );

  // Handshake chain from the output register back to the input.
  logic so_en, sm_en, pw_ready, s0_en;
  logic div_ready [NDS];

  // Stage 0: clamp the limits and classify the sample.
  logic [16:0]     d_c, dmarg, sxn_c, sxp_c, ax;
  logic            xneg;
  jarc_pkg::side_t side0_d, side0_q;
  jarc_pkg::div_t  div0_d, div0_q;
  logic            v0_q;

  always_comb begin
    d_c   = ({1'b0, deadzone_q} > jarc_pkg::Q15_ONE) ? jarc_pkg::Q15_ONE
                                                     : {1'b0, deadzone_q};
    dmarg = d_c + jarc_pkg::SAT_MARGIN;
    sxn_c = ({1'b0, sxn_q} < dmarg) ? dmarg :
            (({1'b0, sxn_q} > jarc_pkg::Q15_ONE) ? jarc_pkg::Q15_ONE : {1'b0, sxn_q});
    sxp_c = ({1'b0, sxp_q} < dmarg) ? dmarg :
            (({1'b0, sxp_q} > jarc_pkg::Q15_ONE) ? jarc_pkg::Q15_ONE : {1'b0, sxp_q});
    xneg  = raw_axis_i[15];
    ax    = xneg ? 17'(17'd0 - {raw_axis_i[15], raw_axis_i}) : {1'b0, raw_axis_i};
    side0_d = '0;
    if (d_c >= jarc_pkg::Q15_ONE) begin
      side0_d.dz = 1'b1;
    end else if (xneg && (ax >= sxn_c)) begin
      side0_d.sat = 1'b1;
      side0_d.neg = 1'b1;
    end else if (!xneg && (ax >= sxp_c)) begin
      side0_d.sat = 1'b1;
    end else if (ax > d_c) begin
      side0_d.neg = xneg;
    end else begin
      side0_d.dz = 1'b1;
    end
    div0_d.rem = 16'(ax - d_c);
    div0_d.den = 16'(xneg ? (sxn_c - d_c) : (sxp_c - d_c));
    div0_d.quo = 16'd0;
  end

  assign s0_en      = !v0_q || div_ready[0];
  assign in_ready_o = s0_en && !recip_busy && !curv_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (s0_en) begin
      v0_q <= in_valid_i && in_ready_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      side0_q <= side0_d;
      div0_q  <= div0_d;
    end
  end

  // Divider: u = ((|x| - deadzone) << 16) / (satX - deadzone), two bits a stage.
  logic            div_v    [NDS+1];
  jarc_pkg::div_t  div_dat  [NDS+1];
  jarc_pkg::side_t div_side [NDS+1];
  logic            div_rdy  [NDS+1];

  assign div_v[0]    = v0_q;
  assign div_dat[0]  = div0_q;
  assign div_side[0] = side0_q;

  for (genvar g = 0; g < NDS; g++) begin : g_div
    jarc_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (div_v[g]),
      .ready_o (div_ready[g]),
      .div_i   (div_dat[g]),
      .side_i  (div_side[g]),
      .valid_o (div_v[g+1]),
      .ready_i (div_rdy[g+1]),
      .div_o   (div_dat[g+1]),
      .side_o  (div_side[g+1])
    );
    if (g > 0) begin : g_rdy
      assign div_rdy[g] = div_ready[g];
    end
  end
  assign div_rdy[0]   = div_ready[0];
  assign div_rdy[NDS] = pw_ready;

  // Power stage: u^p.
  logic            pw_v;
  logic [16:0]     pw_r;
  jarc_pkg::side_t pw_side;

  jarc_power u_power (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .expo_i  (expo),
    .valid_i (div_v[NDS]),
    .ready_o (pw_ready),
    .u_i     (div_dat[NDS].quo),
    .side_i  (div_side[NDS]),
    .valid_o (pw_v),
    .ready_i (sm_en),
    .r_o     (pw_r),
    .side_o  (pw_side)
  );

  // Magnitude stage: scale by the Y limit of the sample's side.
  logic [15:0]     yn_c, yp_c, ysel, mag_d, mag_q;
  logic [32:0]     yprod;
  jarc_pkg::side_t sidem_q;
  logic            vm_q;

  always_comb begin
    yn_c  = (syn_q > 16'd32768) ? 16'd32768 : syn_q;
    yp_c  = (syp_q > 16'd32768) ? 16'd32768 : syp_q;
    ysel  = pw_side.neg ? yn_c : yp_c;
    yprod = 33'(ysel) * 33'(pw_r) + 33'd32768;
    if (pw_side.dz) begin
      mag_d = 16'd0;
    end else if (pw_side.sat) begin
      mag_d = ysel;
    end else begin
      mag_d = yprod[31:16];
    end
  end

  assign sm_en = !vm_q || so_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (sm_en) begin
      vm_q <= pw_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sm_en && pw_v) begin
      mag_q   <= mag_d;
      sidem_q <= pw_side;
    end
  end

  // Output stage: inversion and gain with round half away from zero.
  logic        gneg, cneg;
  logic [15:0] gmag;
  logic [31:0] gprod;
  logic [19:0] gmag_r;
  logic [19:0] cmd_d, cmd_q;
  logic        dz_q, sat_q, vo_q;

  always_comb begin
    gneg   = gain_q[15];
    gmag   = gneg ? 16'(16'd0 - gain_q) : gain_q;
    gprod  = 32'(mag_q) * 32'(gmag) + 32'd2048;
    gmag_r = gprod[31:12];
    cneg   = sidem_q.neg ^ invert_q ^ gneg;
    cmd_d  = cneg ? 20'(20'd0 - gmag_r) : gmag_r;
  end

  assign so_en = !vo_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (so_en) begin
      vo_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (so_en && vm_q) begin
      cmd_q <= cmd_d;
      dz_q  <= sidem_q.dz;
      sat_q <= sidem_q.sat;
    end
  end

  assign out_valid_o     = vo_q;
  assign command_value_o = cmd_q;
  assign in_deadzone_o   = dz_q;
  assign saturated_o     = sat_q;

  // A sample is never both inside the deadzone and saturated.
  `JARC_ASSERT(a_flags_exclusive, out_valid_o |-> !(in_deadzone_o && saturated_o), "deadzone and saturation flags both set")

  // A deadzone sample always yields a zero command.
  `JARC_ASSERT(a_deadzone_zero, (out_valid_o && in_deadzone_o) |-> (command_value_o == 20'sd0), "nonzero command inside deadzone")

  // The command never exceeds eight times full scale.
  `JARC_ASSERT(a_cmd_range, out_valid_o |-> ((command_value_o <= 20'sd262144) && (command_value_o >= -20'sd262144)), "command out of range")

endmodule

[src/jarc_div_stage.sv]
// Two quotient bits of the restoring divider per stage.
module jarc_div_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  jarc_pkg::div_t   div_i,
  input  jarc_pkg::side_t  side_i,
  output logic             valid_o,
  input  logic             ready_i,
  output jarc_pkg::div_t   div_o,
  output jarc_pkg::side_t  side_o
);

  logic            valid_q;
  jarc_pkg::div_t  div_q, div_d;
  jarc_pkg::side_t side_q;
  logic            en;

  logic [16:0] rs0, rs1;
  logic [15:0] r0;
  logic        ge0, ge1;

  assign en = !valid_q || ready_i;

  always_comb begin
    rs0   = {div_i.rem, 1'b0};
    ge0   = rs0 >= {1'b0, div_i.den};
    r0    = ge0 ? 16'(rs0 - {1'b0, div_i.den}) : rs0[15:0];
    rs1   = {r0, 1'b0};
    ge1   = rs1 >= {1'b0, div_i.den};
    div_d.den = div_i.den;
    div_d.rem = ge1 ? 16'(rs1 - {1'b0, div_i.den}) : rs1[15:0];
    div_d.quo = {div_i.quo[13:0], ge0, ge1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      div_q  <= div_d;
      side_q <= side_i;
    end
  end

  assign ready_o = en;
  assign valid_o = valid_q;
  assign div_o   = div_q;
  assign side_o  = side_q;

endmodule

[src/jarc_power.sv]
// u^p as exp2(p * log2 u) in seven stages.
module jarc_power (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [jarc_pkg::EXP_W-1:0] expo_i,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [15:0]                u_i,
  input  jarc_pkg::side_t            side_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [16:0]                r_o,
  output jarc_pkg::side_t            side_o
);

  localparam int IW = jarc_pkg::TAB_IDX_W;
  localparam int TW = jarc_pkg::TAB_W;
  localparam int EW = jarc_pkg::EXP_W;
  localparam int NS = 7;

  logic [NS-1:0]   v_q;
  logic [NS-1:0]   en;
  jarc_pkg::side_t side_q [NS];

  always_comb begin
    en[NS-1] = !v_q[NS-1] || ready_i;
    for (int k = NS - 2; k >= 0; k--) en[k] = !v_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && valid_i) side_q[0] <= side_i;
    for (int k = 1; k < NS; k++) begin
      if (en[k] && v_q[k-1]) side_q[k] <= side_q[k-1];
    end
  end

  // Stage 1: normalize u.
  logic [3:0]  s_d, s1_q;
  logic [15:0] un;
  logic [14:0] frac1_q;
  logic        zero1_q;

  always_comb begin
    s_d = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (u_i[i]) s_d = 4'(15 - i);
    end
    un = u_i << s_d;
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && valid_i) begin
      s1_q    <= s_d;
      frac1_q <= un[14:0];
      zero1_q <= (u_i == 16'd0);
    end
  end

  // Stage 2: log table reads.
  logic [15+IW-1:0] lpos;
  logic [IW-1:0]    lidx;
  logic [IW:0]      lidx_n;
  logic [TW-1:0]    llo2_q, lhi2_q;
  logic [14:0]      lrem2_q;
  logic [3:0]       s2_q;
  logic             zero2_q;

  always_comb begin
    lpos   = {frac1_q, {IW{1'b0}}};
    lidx   = lpos[15+IW-1 -: IW];
    lidx_n = {1'b0, lidx} + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (en[1] && v_q[0]) begin
      llo2_q  <= jarc_pkg::LOG_TAB[{1'b0, lidx}];
      lhi2_q  <= jarc_pkg::LOG_TAB[lidx_n];
      lrem2_q <= lpos[14:0];
      s2_q    <= s1_q;
      zero2_q <= zero1_q;
    end
  end

  // Stage 3: interpolate and form the positive log magnitude.
  logic [TW+14:0] lip;
  logic [TW-1:0]  lg;
  logic [20:0]    a_d, a3_q;
  logic           zero3_q;

  always_comb begin
    lip = (TW+15)'(lhi2_q - llo2_q) * (TW+15)'(lrem2_q);
    lg  = llo2_q + TW'(lip >> 15);
    a_d = {5'({1'b0, s2_q} + 5'd1), 16'd0} - 21'(lg);
  end

  always_ff @(posedge clk_i) begin
    if (en[2] && v_q[1]) begin
      a3_q    <= a_d;
      zero3_q <= zero2_q;
    end
  end

  // Stage 4: scale by the exponent.
  logic [EW+20:0] bm;
  logic [EW+4:0]  b;
  logic [4:0]     q4_q;
  logic [15:0]    f4_q;
  logic           zero4_q;

  always_comb begin
    bm = (EW+21)'(expo_i) * (EW+21)'(a3_q);
    b  = (EW+5)'(bm >> 16);
  end

  always_ff @(posedge clk_i) begin
    if (en[3] && v_q[2]) begin
      q4_q    <= b[20:16];
      f4_q    <= b[15:0];
      zero4_q <= zero3_q || (b[EW+4:16] >= (EW-11)'(31));
    end
  end

  // Stage 5: exp table reads at 1 - frac.
  logic [16:0]      t;
  logic [17+IW-1:0] epos;
  logic [IW:0]      eidx, eidx_n;
  logic [TW-1:0]    elo5_q, ehi5_q;
  logic [15:0]      erem5_q;
  logic [4:0]       q5_q;
  logic             zero5_q;

  always_comb begin
    t      = 17'h10000 - {1'b0, f4_q};
    epos   = {t, {IW{1'b0}}};
    eidx   = epos[16+IW -: IW+1];
    eidx_n = (eidx == (IW+1)'(jarc_pkg::CURVE_TABLE_DEPTH)) ? eidx : eidx + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (en[4] && v_q[3]) begin
      elo5_q  <= jarc_pkg::EXP_TAB[eidx];
      ehi5_q  <= jarc_pkg::EXP_TAB[eidx_n];
      erem5_q <= epos[15:0];
      q5_q    <= q4_q;
      zero5_q <= zero4_q;
    end
  end

  // Stage 6: interpolate 2^(1 - frac).
  logic [TW+15:0] eip;
  logic [TW-1:0]  g6_q;
  logic [4:0]     q6_q;
  logic           zero6_q;

  always_comb begin
    eip = (TW+16)'(ehi5_q - elo5_q) * (TW+16)'(erem5_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[5] && v_q[4]) begin
      g6_q    <= elo5_q + TW'(eip >> 16);
      q6_q    <= q5_q;
      zero6_q <= zero5_q;
    end
  end

  // Stage 7: apply the integer part of the exponent.
  logic [16:0] r7_q;
  logic [TW-1:0] gsh;

  assign gsh = g6_q >> ({1'b0, q6_q} + 6'd1);

  always_ff @(posedge clk_i) begin
    if (en[6] && v_q[5]) begin
      r7_q <= zero6_q ? 17'd0 : gsh[16:0];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];
  assign r_o     = r7_q;
  assign side_o  = side_q[NS-1];

endmodule

[src/jarc_recip.sv]
// Curve exponent in Q16; the reciprocal is found by bit-serial division.
module jarc_recip (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [15:0]                curv_i,
  output logic [jarc_pkg::EXP_W-1:0] expo_o,
  output logic                       busy_o
);

  localparam int EW = jarc_pkg::EXP_W;
  localparam int RW = jarc_pkg::RECIP_W;

  logic [EW-1:0] expo_q, ediv_q, rem_q;
  logic [RW-1:0] quo_q;
  logic [4:0]    cnt_q;
  logic          busy_q;

  logic [15:0] cmag;
  logic [EW-1:0] e_new;
  logic [EW:0]   rs;
  logic          ge;

  always_comb begin
    cmag  = curv_i[15] ? 16'(16'd0 - curv_i) : curv_i;
    e_new = EW'(65536) + EW'(2 * (jarc_pkg::MAX_CURVE_POWER - 1)) * EW'(cmag);
    rs    = {rem_q, 1'b0};
    ge    = rs >= {1'b0, ediv_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 5'd0;
      expo_q <= EW'(65536);
    end else if (start_i) begin
      if (curv_i[15]) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(RW);
      end else begin
        expo_q <= e_new;
      end
    end else if (busy_q) begin
      cnt_q <= cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_q <= 1'b0;
        expo_q <= EW'({quo_q[RW-2:0], ge});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ediv_q <= e_new;
      rem_q  <= EW'(1 << (32 - RW));
      quo_q  <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? EW'(rs - {1'b0, ediv_q}) : rs[EW-1:0];
      quo_q <= {quo_q[RW-2:0], ge};
    end
  end

  assign expo_o = expo_q;
  assign busy_o = busy_q;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

// Testbench for the joystick axis response curve core.
//
// A queue of pending axis samples, filled by the main initial block, feeds a
// clocked driver that offers one sample per transfer on the input channel.
// Every accepted sample is run through a cycle-free predictor of the curve:
// deadzone, saturation, power-law shaping through interpolated log/exp tables,
// inversion and gain. The predicted result is added to a queue of pending
// commands. A clocked monitor pops the oldest pending command for every
// output transfer and compares it field by field.
//
// Configuration is written only while the pipeline is empty. The run covers
// the reset settings, a directed set of extreme settings, and then three
// stretches of random settings with different idle patterns on the two sides.
module tb_top;

  localparam int LOG_DEPTH = jarc_pkg::CURVE_TABLE_DEPTH;
  localparam int POW_MAX   = jarc_pkg::MAX_CURVE_POWER;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [19:0] cmd;
    logic        dz;
    logic        sat;
  } command_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic signed [15:0] raw_axis_i;
  logic out_valid_o;
  logic out_ready_i;
  logic signed [19:0] command_value_o;
  logic in_deadzone_o;
  logic saturated_o;
  logic cfg_we_i;
  logic [jarc_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [15:0] cfg_wdata_i;

  joystick_axis_response_curve_core DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .raw_axis_i,
    .out_valid_o,
    .out_ready_i,
    .command_value_o,
    .in_deadzone_o,
    .saturated_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i
  );

  // Shadow copy of the register file, updated as each write is issued.
  logic [15:0] deadzone_r, sat_xn_r, sat_xp_r, sat_yn_r, sat_yp_r;
  logic [15:0] curvature_r, gain_r;
  logic        invert_r;

  longint unsigned log2_lut [0:LOG_DEPTH];
  longint unsigned exp2_lut [0:LOG_DEPTH];

  logic [15:0] pending_samples [$];
  command_t    pending_commands [$];

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned hold_request;
  int unsigned hold_seen;
  int unsigned hold_left;
  logic        in_taken;
  int unsigned mismatches;
  int unsigned samples_sent;
  int unsigned commands_checked;
  int unsigned settings_used;
  int unsigned dz_seen;
  int unsigned sat_seen;

  // Clock: 10 ns period.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic void add_sample(logic [15:0] v);
    pending_samples.insert(pending_samples.size(), v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n_in);
    longint unsigned n, res, b;
    n   = n_in;
    res = 0;
    b   = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n   = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Fills the log2(1+i/N) and 2^(i/N) tables in Q16, by integer arithmetic only.
  task automatic fill_curve_tables();
    longint unsigned roots [20];
    longint unsigned x, f, acc;
    int unsigned     y, b;
    roots[0] = int_sqrt(64'd1 << 61);
    for (int k = 1; k < 20; k++) roots[k] = int_sqrt(roots[k-1] << 30);
    for (int i = 0; i < LOG_DEPTH; i++) begin
      x = (64'd1 << 30) + ((longint'(i) << 30) / LOG_DEPTH);
      y = 0;
      b = 1 << 17;
      while (b != 0) begin
        x = (x * x) >> 30;
        if (x >= (64'd1 << 31)) begin
          x = x >> 1;
          y = y | b;
        end
        b = b >> 1;
      end
      log2_lut[i] = (y + 2) >> 2;
      f   = (longint'(i) << 20) / LOG_DEPTH;
      acc = 64'd1 << 30;
      for (int k = 0; k < 20; k++) begin
        if ((f >> (19 - k)) & 1) acc = (acc * roots[k] + (64'd1 << 29)) >> 30;
      end
      exp2_lut[i] = (acc + (64'd1 << 13)) >> 14;
    end
    log2_lut[LOG_DEPTH] = 65536;
    exp2_lut[LOG_DEPTH] = 131072;
  endtask

  // u^e with u in Q0.16 and e in Q16, computed as 2^(-e * -log2 u).
  function automatic longint unsigned curve_power(longint unsigned u, longint unsigned e);
    longint unsigned s, frac, pos, idx, rem, lg, a, bexp, q, f, t, g;
    if (u == 0) return 0;
    s = 0;
    while ((u << s) < 32768) s++;
    frac = (u << s) - 32768;
    pos  = frac * LOG_DEPTH;
    idx  = pos >> 15;
    rem  = pos & 32767;
    if (idx >= LOG_DEPTH) lg = log2_lut[LOG_DEPTH];
    else lg = log2_lut[idx] + (((log2_lut[idx+1] - log2_lut[idx]) * rem) >> 15);
    a    = (s + 1) * 65536 - lg;
    bexp = (e * a) >> 16;
    if ((bexp >> 16) >= 31) return 0;
    q   = bexp >> 16;
    f   = bexp & 16'hFFFF;
    t   = 65536 - f;
    pos = t * LOG_DEPTH;
    idx = pos >> 16;
    rem = pos & 16'hFFFF;
    if (idx >= LOG_DEPTH) g = exp2_lut[LOG_DEPTH];
    else g = exp2_lut[idx] + (((exp2_lut[idx+1] - exp2_lut[idx]) * rem) >> 16);
    return g >> (q + 1);
  endfunction

  // Expected command for one axis sample under the current register settings.
  function automatic command_t shape_axis(logic signed [15:0] raw);
    command_t        res;
    int              x, c, gain, cmd;
    longint unsigned d, sxn, sxp, yn, yp, mag, e, cmag, gmag, prod, ax, den, u, r, ylim;
    logic            neg, gneg;
    x    = raw;
    c    = $signed(curvature_r);
    gain = $signed(gain_r);
    d    = (deadzone_r > 32768) ? 32768 : deadzone_r;
    sxn  = sat_xn_r;
    sxp  = sat_xp_r;
    yn   = (sat_yn_r > 32768) ? 32768 : sat_yn_r;
    yp   = (sat_yp_r > 32768) ? 32768 : sat_yp_r;
    mag  = 0;
    neg  = 1'b0;
    res  = '0;
    if (d >= 32768) begin
      res.dz = 1'b1;
    end else begin
      // Saturation points sit at least a hundredth past the deadzone.
      if (sxn < d + 328) sxn = d + 328;
      else if (sxn > 32768) sxn = 32768;
      if (sxp < d + 328) sxp = d + 328;
      else if (sxp > 32768) sxp = 32768;
      cmag = (c < 0) ? -c : c;
      e    = 65536 + (POW_MAX - 1) * cmag * 2;
      if (c < 0) e = (64'd1 << 32) / e;
      if (x <= -int'(sxn)) begin
        mag = yn;
        neg = 1'b1;
        res.sat = 1'b1;
      end else if (x >= int'(sxp)) begin
        mag = yp;
        res.sat = 1'b1;
      end else if (x < -int'(d) || x > int'(d)) begin
        ax   = (x < 0) ? -x : x;
        den  = ((x < 0) ? sxn : sxp) - d;
        u    = ((ax - d) << 16) / den;
        r    = curve_power(u, e);
        ylim = (x < 0) ? yn : yp;
        neg  = (x < 0);
        mag  = (ylim * r + 32768) >> 16;
      end else begin
        res.dz = 1'b1;
      end
    end
    if (invert_r) neg = !neg;
    gneg = (gain < 0);
    gmag = (gain < 0) ? -gain : gain;
    prod = (mag * gmag + 2048) >> 12;
    cmd  = int'(prod);
    if (neg != gneg) cmd = -cmd;
    res.cmd = cmd[19:0];
    return res;
  endfunction

  // Input side: a new sample is offered once the previous one has transferred.
  always @(posedge clk_i) begin
    in_taken <= in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      pending_commands.insert(pending_commands.size(), shape_axis(raw_axis_i));
      samples_sent++;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_samples.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_valid_i <= 1'b1;
        raw_axis_i <= pending_samples.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output side: random stalls, plus a long hold-off on request so that the
  // pipeline fills up and the input side backs off.
  always @(negedge clk_i) begin
    if (hold_request != hold_seen) begin
      hold_seen   <= hold_request;
      hold_left   <= 300;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    command_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_commands.size() == 0) begin
        $error("Result transfer with no pending command: cmd=%0d", command_value_o);
        mismatches++;
      end else begin
        want = pending_commands.pop_front();
        commands_checked++;
        if (want.dz) dz_seen++;
        if (want.sat) sat_seen++;
        if (command_value_o !== want.cmd) begin
          $error("command_value: expected %0d, actual %0d",
                 $signed(want.cmd), command_value_o);
          mismatches++;
        end
        if (in_deadzone_o !== want.dz) begin
          $error("in_deadzone: expected %0b, actual %0b", want.dz, in_deadzone_o);
          mismatches++;
        end
        if (saturated_o !== want.sat) begin
          $error("saturated: expected %0b, actual %0b", want.sat, saturated_o);
          mismatches++;
        end
      end
    end
  end

  task automatic write_register(logic [jarc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      jarc_pkg::REG_DEADZONE:  deadzone_r  = val;
      jarc_pkg::REG_SAT_X_NEG: sat_xn_r    = val;
      jarc_pkg::REG_SAT_X_POS: sat_xp_r    = val;
      jarc_pkg::REG_SAT_Y_NEG: sat_yn_r    = val;
      jarc_pkg::REG_SAT_Y_POS: sat_yp_r    = val;
      jarc_pkg::REG_CURVATURE: curvature_r = val;
      jarc_pkg::REG_INVERT:    invert_r    = val[0];
      jarc_pkg::REG_GAIN:      gain_r      = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [15:0] dz, logic [15:0] sxn, logic [15:0] sxp,
                                logic [15:0] yn, logic [15:0] yp, logic [15:0] curv,
                                logic inv, logic [15:0] gain);
    write_register(jarc_pkg::REG_DEADZONE, dz);
    write_register(jarc_pkg::REG_SAT_X_NEG, sxn);
    write_register(jarc_pkg::REG_SAT_X_POS, sxp);
    write_register(jarc_pkg::REG_SAT_Y_NEG, yn);
    write_register(jarc_pkg::REG_SAT_Y_POS, yp);
    write_register(jarc_pkg::REG_CURVATURE, curv);
    write_register(jarc_pkg::REG_INVERT, {15'd0, inv});
    write_register(jarc_pkg::REG_GAIN, gain);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Waits until every sample has been sent and every command has come back,
  // then lets the pipeline settle before any register is touched.
  task automatic wait_for_idle();
    while (pending_samples.size() > 0 || in_valid_i || pending_commands.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_q15_limit();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'hFFFF;
      3: return 16'($urandom_range(65535));
      default: return 16'($urandom_range(32768, 8000));
    endcase
  endfunction

  task automatic apply_random_settings();
    logic [15:0] dz, curv, gain;
    case ($urandom_range(9))
      0: dz = 16'd0;
      1: dz = 16'd32768;
      2: dz = 16'($urandom_range(65535));
      3: dz = 16'($urandom_range(32767, 30000));
      default: dz = 16'($urandom_range(6000));
    endcase
    case ($urandom_range(5))
      0: curv = 16'h8000;
      1: curv = 16'h7FFF;
      2: curv = 16'd0;
      default: curv = 16'($urandom);
    endcase
    case ($urandom_range(5))
      0: gain = 16'h8000;
      1: gain = 16'h7FFF;
      2: gain = 16'd4096;
      default: gain = 16'($urandom);
    endcase
    apply_settings(dz, pick_q15_limit(), pick_q15_limit(), pick_q15_limit(),
                   pick_q15_limit(), curv, 1'($urandom), gain);
  endtask

  // Random samples, a share of them placed close to the deadzone edge and the
  // saturation points of the current settings.
  task automatic queue_random_samples(int unsigned count);
    int edge_pt, off;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 7) begin
        add_sample(16'($urandom));
      end else begin
        case ($urandom_range(2))
          0: edge_pt = deadzone_r;
          1: edge_pt = sat_xn_r;
          default: edge_pt = sat_xp_r;
        endcase
        off = $urandom_range(700) - 350;
        edge_pt = edge_pt + off;
        if ($urandom_range(1)) edge_pt = -edge_pt;
        if (edge_pt > 32767) edge_pt = 32767;
        if (edge_pt < -32768) edge_pt = -32768;
        add_sample(16'(edge_pt));
      end
    end
  endtask

  task automatic queue_directed_samples();
    add_sample(16'sd0);
    add_sample(16'sd1);
    add_sample(-16'sd1);
    add_sample(16'sd32767);
    add_sample(-16'sd32768);
    add_sample(16'sd16384);
    add_sample(-16'sd12000);
  endtask

  initial begin
    int unsigned tx_pct [3] = '{8, 67, 0};
    int unsigned rx_pct [3] = '{67, 8, 0};
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    raw_axis_i   = '0;
    out_ready_i  = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = jarc_pkg::REG_DEADZONE;
    cfg_wdata_i  = '0;
    in_taken     = 1'b0;
    hold_request = 0;
    hold_seen    = 0;
    hold_left    = 0;
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    mismatches   = 0;
    samples_sent = 0;
    commands_checked = 0;
    settings_used = 0;
    dz_seen      = 0;
    sat_seen     = 0;
    deadzone_r   = 16'd0;
    sat_xn_r     = 16'd32768;
    sat_xp_r     = 16'd32768;
    sat_yn_r     = 16'd32768;
    sat_yp_r     = 16'd32768;
    curvature_r  = 16'd0;
    invert_r     = 1'b0;
    gain_r       = 16'd4096;
    fill_curve_tables();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. Reset settings: unity curve, and an exact zero sample
    // counts as inside the zero-width deadzone.
    queue_directed_samples();
    wait_for_idle();
    // Deadzone of one and above: every sample is forced to zero.
    apply_settings(16'hFFFF, 16'd32768, 16'd32768, 16'd32768, 16'd32768,
                   16'd0, 1'b0, 16'd4096);
    add_sample(16'sd32767);
    add_sample(-16'sd32768);
    wait_for_idle();
    // Saturation X below the margin, Y limits above one, steepest curve,
    // inverted output with the most negative gain.
    apply_settings(16'd1000, 16'd0, 16'd500, 16'hFFFF, 16'd40000,
                   16'h7FFF, 1'b1, 16'h8000);
    add_sample(16'sd1328);
    add_sample(-16'sd1327);
    add_sample(16'sd1001);
    add_sample(-16'sd1000);
    add_sample(16'sd1200);
    wait_for_idle();
    // Strongest reciprocal power, where tiny inputs still give small outputs,
    // and the largest positive gain.
    apply_settings(16'd0, 16'd32768, 16'd20000, 16'd32768, 16'd0,
                   16'h8000, 1'b0, 16'h7FFF);
    add_sample(16'sd1);
    add_sample(-16'sd2);
    add_sample(16'sd19999);
    add_sample(-16'sd32767);
    add_sample(16'sd0);
    wait_for_idle();

    // Random part: three idle patterns, four settings each.
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = tx_pct[ph];
      rx_idle_pct = rx_pct[ph];
      for (int s = 0; s < 4; s++) begin
        apply_random_settings();
        queue_random_samples(125);
        // With no idling, stop the receiver for a long stretch while the
        // sender keeps offering samples.
        if (ph == 2 && s == 0) hold_request++;
        wait_for_idle();
      end
    end

    $display("Checked %0d commands from %0d samples over %0d register settings.",
             commands_checked, samples_sent, settings_used);
    $display("Deadzone results: %0d, saturated results: %0d, mismatches: %0d.",
             dz_seen, sat_seen, mismatches);
    if (mismatches == 0 && pending_commands.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d commands pending.", pending_commands.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
